### rtl/nbgs_pkg.sv
// Shared types, constants and helpers for the 2D direct-sum gravity stepper.
// No dependencies; imported by every module of the block.
package nbgs_pkg;

   // Body storage limits
   localparam int MAX_BODIES = 64;
   localparam int IDX_W      = $clog2(MAX_BODIES);
   localparam int CNT_W      = IDX_W + 1;

   // Arithmetic unit widths
   localparam int DIV_W      = 82;              // dividend / quotient width
   localparam int DEN_W      = 64;              // divisor width
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int RT_W       = 64;              // square root radicand width
   localparam int RT_OUT_W   = RT_W / 2;
   localparam int RT_CNT_W   = $clog2(RT_OUT_W);
   localparam int SAT_W      = 43;              // headroom for velocity/position adds

   // Request queue
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   // Fixed-point caps
   localparam logic [30:0] UNIT_ONE = 31'h4000_0000;
   localparam logic [31:0] ACC_CAP  = 32'hFFFF_FFFF;

   // Register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFTENING  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP  = 3'd4;

   // Register reset values
   localparam logic [6:0]  RST_BODY_COUNT = 7'd64;
   localparam logic [15:0] RST_STEP_COUNT = 16'd1;
   localparam logic [23:0] RST_GRAVITY    = 24'd65536;
   localparam logic [31:0] RST_SOFTENING  = 32'd429497;
   localparam logic [7:0]  RST_TIME_STEP  = 8'd1;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [25:0] mass;
   } body_type;

   // One queue entry: optional body store, optional run start
   typedef struct packed {
      logic             do_load;
      logic             do_run;
      logic [IDX_W-1:0] index;
      logic [CNT_W-1:0] count;
      body_type         body;
   } cmd_type;

   typedef struct packed {
      logic [6:0]  body_count;
      logic [15:0] step_count;
      logic [23:0] gravity_const;
      logic [31:0] softening;
      logic [7:0]  time_step;
   } cfg_type;

   // Saturate a two's complement value to signed 32 bits
   function automatic logic [31:0] sat32(input logic [SAT_W-1:0] v);
      logic [SAT_W-32:0] upper;
      logic [31:0]       r;
      upper = v[SAT_W-1:31];
      if (upper == '0 || upper == '1) begin
         r = v[31:0];
      end else if (v[SAT_W-1]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

### rtl/nbgs_front.sv
// Request front end: load counting, drop of overflow bodies, run detection.
// Depends on nbgs_pkg; feeds nbgs_queue.
module nbgs_front
   import nbgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [31:0]      req_pos_x,
   input  logic [31:0]      req_pos_y,
   input  logic [31:0]      req_vel_x,
   input  logic [31:0]      req_vel_y,
   input  logic [25:0]      req_body_mass,
   input  logic             req_last_body,
   input  logic [6:0]       body_count,
   input  logic             q_full,
   output logic             q_push,
   output cmd_type          q_cmd
);

   logic [CNT_W-1:0] load_count_ff, load_count_in;
   logic [CNT_W-1:0] limit;
   logic             accept;
   logic             do_load;

   // Clamp the configured body count into the supported range
   always_comb begin
      if (body_count < CNT_W'(2)) begin
         limit = CNT_W'(2);
      end else if (body_count > CNT_W'(MAX_BODIES)) begin
         limit = CNT_W'(MAX_BODIES);
      end else begin
         limit = body_count;
      end
   end

   assign busy    = q_full;
   assign accept  = start & ~q_full;
   assign do_load = load_count_ff < limit;
   assign q_push  = accept & (do_load | req_last_body);

   // Classify the request
   always_comb begin
      q_cmd.do_load    = do_load;
      q_cmd.do_run     = req_last_body;
      q_cmd.index      = load_count_ff[IDX_W-1:0];
      q_cmd.count      = load_count_ff + CNT_W'(do_load);
      q_cmd.body.pos_x = req_pos_x;
      q_cmd.body.pos_y = req_pos_y;
      q_cmd.body.vel_x = req_vel_x;
      q_cmd.body.vel_y = req_vel_y;
      q_cmd.body.mass  = req_body_mass;
   end

   always_comb begin
      load_count_in = load_count_ff;
      if (accept) begin
         if (req_last_body) begin
            load_count_in = '0;
         end else if (do_load) begin
            load_count_in = load_count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

endmodule

### rtl/nbgs_queue.sv
// Short request queue between the front end and the step engine.
// Depends on nbgs_pkg.
module nbgs_queue
   import nbgs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    full,
   output logic    empty
);

   cmd_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full    = count_ff == Q_CNT_W'(Q_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/nbgs_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nbgs_pkg; used by nbgs_back.
module nbgs_divider
   import nbgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [DIV_W-1:0] quot
);

   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       rem_sh;
   logic [DEN_W:0]       rem_sub;
   logic                 ge;

   assign rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign done    = done_ff;
   assign quot    = quo_ff;

   // Shift in one dividend bit, subtract when it fits
   always_comb begin
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in    = '0;
         quo_in    = num;
         den_in    = den;
         cnt_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         rem_in = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

endmodule

### rtl/nbgs_isqrt.sv
// Integer square root, one result bit per cycle (digit-by-digit method).
// Depends on nbgs_pkg; used by nbgs_back.
module nbgs_isqrt
   import nbgs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [RT_W-1:0]     value,
   output logic                done,
   output logic [RT_OUT_W-1:0] root
);

   logic [RT_W-1:0]     v_ff, v_in;
   logic [RT_W-1:0]     r_ff, r_in;
   logic [RT_W-1:0]     bit_ff, bit_in;
   logic [RT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                active_ff, active_in;
   logic                done_ff, done_in;
   logic [RT_W-1:0]     trial;

   assign trial = r_ff + bit_ff;
   assign done  = done_ff;
   assign root  = r_ff[RT_OUT_W-1:0];

   always_comb begin
      v_in      = v_ff;
      r_in      = r_ff;
      bit_in    = bit_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         v_in      = value;
         r_in      = '0;
         bit_in    = {2'b01, {(RT_W-2){1'b0}}};
         cnt_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + RT_CNT_W'(1);
         if (cnt_ff == RT_CNT_W'(RT_OUT_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

endmodule

### rtl/nbgs_back.sv
// Step engine: body memory, pair force sequencer, motion update, result emission.
// Depends on nbgs_pkg, nbgs_divider and nbgs_isqrt.
module nbgs_back
   import nbgs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             q_empty,
   input  cmd_type          q_cmd,
   output logic             q_pop,
   output logic             rsp_strobe,
   output logic [IDX_W-1:0] rsp_body_index,
   output logic [31:0]      rsp_out_pos_x,
   output logic [31:0]      rsp_out_pos_y,
   output logic [31:0]      rsp_out_vel_x,
   output logic [31:0]      rsp_out_vel_y,
   output logic             rsp_last_result
);

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_PR_RD_I, ST_PR_RD_J, ST_PR_GET_J, ST_PR_DIFF, ST_PR_ABS,
      ST_PR_SQX, ST_PR_SQY, ST_PR_H2, ST_PR_S,
      ST_RT_S_GO, ST_RT_S_WT, ST_RT_H_GO, ST_RT_H_WT,
      ST_UX_GO, ST_UX_WT, ST_UY_GO, ST_UY_WT,
      ST_GM, ST_T_GO, ST_T_WT, ST_F_GO, ST_F_WT,
      ST_DV_MUL, ST_DV_SCL, ST_DV_ADD,
      ST_WR_I, ST_WR_J, ST_PR_NEXT,
      ST_MV_RD, ST_MV_GET, ST_MV_MUL, ST_MV_ADD, ST_MV_WR,
      ST_OUT_RD, ST_OUT_EMIT
   } state_type;

   // Body memory
   body_type         mem [MAX_BODIES];
   body_type         rd_q_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;
   body_type         mem_wdata;

   // Sequencer state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [15:0]      steps_ff, steps_in;
   logic [1:0]       k_ff, k_in;
   logic             side_ff, side_in;

   // Pair datapath registers
   body_type         a_ff, a_in;
   body_type         b_ff, b_in;
   logic [32:0]      dx_ff, dx_in;
   logic [32:0]      dy_ff, dy_in;
   logic             dx_neg_ff, dx_neg_in;
   logic             dy_neg_ff, dy_neg_in;
   logic [31:0]      ax_ff, ax_in;
   logic [31:0]      ay_ff, ay_in;
   logic [63:0]      ax2_ff, ax2_in;
   logic [63:0]      ay2_ff, ay2_in;
   logic [63:0]      h2_ff, h2_in;
   logic [63:0]      s_ff, s_in;
   logic [31:0]      root_ff, root_in;
   logic [31:0]      half_ff, half_in;
   logic [30:0]      ux_ff, ux_in;
   logic [30:0]      uy_ff, uy_in;
   logic [49:0]      gm_ff, gm_in;
   logic [63:0]      t_ff, t_in;
   logic [31:0]      fa_ff, fa_in;
   logic [31:0]      fb_ff, fb_in;
   logic [62:0]      prod_ff, prod_in;
   logic [40:0]      dv_ff, dv_in;
   logic [40:0]      mvx_ff, mvx_in;
   logic [40:0]      mvy_ff, mvy_in;

   // Registered result outputs
   logic             strobe_ff, strobe_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   body_type         rbody_ff, rbody_in;
   logic             rlast_ff, rlast_in;

   // Shared arithmetic units
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_num, div_q;
   logic [DEN_W-1:0]    div_den;
   logic                rt_start, rt_done;
   logic [RT_W-1:0]     rt_val;
   logic [RT_OUT_W-1:0] rt_res;

   // Helper values
   logic [64:0]      sq_sum;
   logic [30:0]      u_capped;
   logic [31:0]      f_capped;
   logic [31:0]      f_sel;
   logic [30:0]      u_sel;
   logic [31:0]      v_sel;
   logic             plus_sel;
   logic [SAT_W-1:0] v_ext;
   logic [SAT_W-1:0] dv_ext;
   logic [SAT_W-1:0] dv_sum;
   logic [31:0]      v_new;
   logic [25:0]      mass_sel;
   logic             last_i;
   logic             last_j;
   logic             last_pair_i;

   nbgs_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   nbgs_isqrt u_rt (
      .clock (clock),
      .reset (reset),
      .start (rt_start),
      .value (rt_val),
      .done  (rt_done),
      .root  (rt_res)
   );

   assign sq_sum      = {1'b0, ax2_ff} + {1'b0, ay2_ff};
   assign u_capped    = (div_q > DIV_W'(UNIT_ONE)) ? UNIT_ONE : div_q[30:0];
   assign f_capped    = (div_q > DIV_W'(ACC_CAP)) ? ACC_CAP : div_q[31:0];
   assign f_sel       = k_ff[1] ? fb_ff : fa_ff;
   assign u_sel       = k_ff[0] ? uy_ff : ux_ff;
   assign mass_sel    = side_ff ? a_ff.mass : b_ff.mass;
   assign last_i      = {1'b0, i_ff} == n_ff - CNT_W'(1);
   assign last_j      = {1'b0, j_ff} == n_ff - CNT_W'(1);
   assign last_pair_i = {1'b0, i_ff} == n_ff - CNT_W'(2);

   // Velocity being updated and the direction toward the other body
   always_comb begin
      case (k_ff)
         2'd0: begin
            v_sel    = a_ff.vel_x;
            plus_sel = ~dx_neg_ff;
         end
         2'd1: begin
            v_sel    = a_ff.vel_y;
            plus_sel = ~dy_neg_ff;
         end
         2'd2: begin
            v_sel    = b_ff.vel_x;
            plus_sel = dx_neg_ff;
         end
         default: begin
            v_sel    = b_ff.vel_y;
            plus_sel = dy_neg_ff;
         end
      endcase
   end

   assign v_ext  = {{(SAT_W-32){v_sel[31]}}, v_sel};
   assign dv_ext = {{(SAT_W-41){1'b0}}, dv_ff};
   assign dv_sum = plus_sel ? v_ext + dv_ext : v_ext - dv_ext;
   assign v_new  = sat32(dv_sum);

   // Sequencer next state
   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      steps_in  = steps_ff;
      k_in      = k_ff;
      side_in   = side_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dx_neg_in = dx_neg_ff;
      dy_neg_in = dy_neg_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      ax2_in    = ax2_ff;
      ay2_in    = ay2_ff;
      h2_in     = h2_ff;
      s_in      = s_ff;
      root_in   = root_ff;
      half_in   = half_ff;
      ux_in     = ux_ff;
      uy_in     = uy_ff;
      gm_in     = gm_ff;
      t_in      = t_ff;
      fa_in     = fa_ff;
      fb_in     = fb_ff;
      prod_in   = prod_ff;
      dv_in     = dv_ff;
      mvx_in    = mvx_ff;
      mvy_in    = mvy_ff;
      strobe_in = 1'b0;
      ridx_in   = ridx_ff;
      rbody_in  = rbody_ff;
      rlast_in  = rlast_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = i_ff;
      mem_wdata = a_ff;
      mem_raddr = i_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      rt_start  = 1'b0;
      rt_val    = '0;

      unique case (state_ff)
         // Take the next queued request
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_cmd.do_load) begin
                  mem_we    = 1'b1;
                  mem_waddr = q_cmd.index;
                  mem_wdata = q_cmd.body;
               end
               if (q_cmd.do_run) begin
                  n_in     = q_cmd.count;
                  steps_in = cfg.step_count;
                  i_in     = '0;
                  j_in     = IDX_W'(1);
                  if (cfg.step_count == '0) begin
                     state_in = ST_OUT_RD;
                  end else if (q_cmd.count >= CNT_W'(2)) begin
                     state_in = ST_PR_RD_I;
                  end else begin
                     state_in = ST_MV_RD;
                  end
               end
            end
         end

         // Fetch both bodies of the pair
         ST_PR_RD_I: begin
            mem_raddr = i_ff;
            state_in  = ST_PR_RD_J;
         end
         ST_PR_RD_J: begin
            mem_raddr = j_ff;
            a_in      = rd_q_ff;
            state_in  = ST_PR_GET_J;
         end
         ST_PR_GET_J: begin
            b_in     = rd_q_ff;
            state_in = ST_PR_DIFF;
         end

         // Separation and squared half distance
         ST_PR_DIFF: begin
            dx_in    = {b_ff.pos_x[31], b_ff.pos_x} - {a_ff.pos_x[31], a_ff.pos_x};
            dy_in    = {b_ff.pos_y[31], b_ff.pos_y} - {a_ff.pos_y[31], a_ff.pos_y};
            state_in = ST_PR_ABS;
         end
         ST_PR_ABS: begin
            dx_neg_in = dx_ff[32];
            dy_neg_in = dy_ff[32];
            ax_in     = dx_ff[32] ? 32'(-dx_ff) : dx_ff[31:0];
            ay_in     = dy_ff[32] ? 32'(-dy_ff) : dy_ff[31:0];
            // coincident bodies exert nothing
            state_in  = (dx_ff == '0 && dy_ff == '0) ? ST_PR_NEXT : ST_PR_SQX;
         end
         ST_PR_SQX: begin
            ax2_in   = 64'(ax_ff) * 64'(ax_ff);
            state_in = ST_PR_SQY;
         end
         ST_PR_SQY: begin
            ay2_in   = 64'(ay_ff) * 64'(ay_ff);
            state_in = ST_PR_H2;
         end
         ST_PR_H2: begin
            h2_in    = {1'b0, sq_sum[64:2]};
            state_in = ST_PR_S;
         end
         ST_PR_S: begin
            s_in     = h2_ff + 64'(cfg.softening);
            state_in = ST_RT_S_GO;
         end

         // Roots of the softened and plain squared half distance
         ST_RT_S_GO: begin
            if (s_ff == '0) begin
               state_in = ST_PR_NEXT;
            end else begin
               rt_start = 1'b1;
               rt_val   = s_ff;
               state_in = ST_RT_S_WT;
            end
         end
         ST_RT_S_WT: begin
            if (rt_done) begin
               root_in  = rt_res;
               state_in = ST_RT_H_GO;
            end
         end
         ST_RT_H_GO: begin
            rt_start = 1'b1;
            rt_val   = h2_ff;
            state_in = ST_RT_H_WT;
         end
         ST_RT_H_WT: begin
            if (rt_done) begin
               half_in  = (rt_res == '0) ? 32'd1 : rt_res;
               state_in = ST_UX_GO;
            end
         end

         // Unit vector components
         ST_UX_GO: begin
            div_start = 1'b1;
            div_num   = {21'b0, ax_ff, 29'b0};
            div_den   = {32'b0, half_ff};
            state_in  = ST_UX_WT;
         end
         ST_UX_WT: begin
            if (div_done) begin
               ux_in    = u_capped;
               state_in = ST_UY_GO;
            end
         end
         ST_UY_GO: begin
            div_start = 1'b1;
            div_num   = {21'b0, ay_ff, 29'b0};
            div_den   = {32'b0, half_ff};
            state_in  = ST_UY_WT;
         end
         ST_UY_WT: begin
            if (div_done) begin
               uy_in    = u_capped;
               side_in  = 1'b0;
               state_in = ST_GM;
            end
         end

         // Acceleration magnitude, first for body i then for body j
         ST_GM: begin
            gm_in    = 50'(cfg.gravity_const) * 50'(mass_sel);
            state_in = ST_T_GO;
         end
         ST_T_GO: begin
            div_start = 1'b1;
            div_num   = {18'b0, gm_ff, 14'b0};
            div_den   = {32'b0, root_ff};
            state_in  = ST_T_WT;
         end
         ST_T_WT: begin
            if (div_done) begin
               t_in     = div_q[63:0];
               state_in = ST_F_GO;
            end
         end
         ST_F_GO: begin
            div_start = 1'b1;
            div_num   = {t_ff, 18'b0};
            div_den   = s_ff;
            state_in  = ST_F_WT;
         end
         ST_F_WT: begin
            if (div_done) begin
               if (!side_ff) begin
                  fa_in    = f_capped;
                  side_in  = 1'b1;
                  state_in = ST_GM;
               end else begin
                  fb_in    = f_capped;
                  side_in  = 1'b0;
                  k_in     = '0;
                  state_in = ST_DV_MUL;
               end
            end
         end

         // Four velocity updates, one component at a time
         ST_DV_MUL: begin
            prod_in  = 63'(f_sel) * 63'(u_sel);
            state_in = ST_DV_SCL;
         end
         ST_DV_SCL: begin
            dv_in    = 41'(prod_ff[62:30]) * 41'(cfg.time_step);
            state_in = ST_DV_ADD;
         end
         ST_DV_ADD: begin
            case (k_ff)
               2'd0:    a_in.vel_x = v_new;
               2'd1:    a_in.vel_y = v_new;
               2'd2:    b_in.vel_x = v_new;
               default: b_in.vel_y = v_new;
            endcase
            k_in     = k_ff + 2'd1;
            state_in = (k_ff == 2'd3) ? ST_WR_I : ST_DV_MUL;
         end

         ST_WR_I: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = a_ff;
            state_in  = ST_WR_J;
         end
         ST_WR_J: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = b_ff;
            state_in  = ST_PR_NEXT;
         end

         // Pair order: increasing i, then increasing j
         ST_PR_NEXT: begin
            if (!last_j) begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_PR_RD_I;
            end else if (!last_pair_i) begin
               i_in     = i_ff + IDX_W'(1);
               j_in     = i_ff + IDX_W'(2);
               state_in = ST_PR_RD_I;
            end else begin
               i_in     = '0;
               state_in = ST_MV_RD;
            end
         end

         // Advance positions
         ST_MV_RD: begin
            mem_raddr = i_ff;
            state_in  = ST_MV_GET;
         end
         ST_MV_GET: begin
            a_in     = rd_q_ff;
            state_in = ST_MV_MUL;
         end
         ST_MV_MUL: begin
            mvx_in   = {{9{a_ff.vel_x[31]}}, a_ff.vel_x} * {33'b0, cfg.time_step};
            mvy_in   = {{9{a_ff.vel_y[31]}}, a_ff.vel_y} * {33'b0, cfg.time_step};
            state_in = ST_MV_ADD;
         end
         ST_MV_ADD: begin
            a_in.pos_x = sat32({{(SAT_W-32){a_ff.pos_x[31]}}, a_ff.pos_x}
                             + {{(SAT_W-41){mvx_ff[40]}}, mvx_ff});
            a_in.pos_y = sat32({{(SAT_W-32){a_ff.pos_y[31]}}, a_ff.pos_y}
                             + {{(SAT_W-41){mvy_ff[40]}}, mvy_ff});
            state_in   = ST_MV_WR;
         end
         ST_MV_WR: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = a_ff;
            if (!last_i) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_MV_RD;
            end else if (steps_ff == 16'd1) begin
               i_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               steps_in = steps_ff - 16'd1;
               i_in     = '0;
               j_in     = IDX_W'(1);
               state_in = (n_ff >= CNT_W'(2)) ? ST_PR_RD_I : ST_MV_RD;
            end
         end

         // Read each body, then emit it as a result
         ST_OUT_RD: begin
            mem_raddr = i_ff;
            state_in  = ST_OUT_EMIT;
         end
         ST_OUT_EMIT: begin
            strobe_in = 1'b1;
            ridx_in   = i_ff;
            rbody_in  = rd_q_ff;
            rlast_in  = last_i;
            if (last_i) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_OUT_RD;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State, datapath and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      n_ff      <= n_in;
      steps_ff  <= steps_in;
      k_ff      <= k_in;
      side_ff   <= side_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dx_neg_ff <= dx_neg_in;
      dy_neg_ff <= dy_neg_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      ax2_ff    <= ax2_in;
      ay2_ff    <= ay2_in;
      h2_ff     <= h2_in;
      s_ff      <= s_in;
      root_ff   <= root_in;
      half_ff   <= half_in;
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
      gm_ff     <= gm_in;
      t_ff      <= t_in;
      fa_ff     <= fa_in;
      fb_ff     <= fb_in;
      prod_ff   <= prod_in;
      dv_ff     <= dv_in;
      mvx_ff    <= mvx_in;
      mvy_ff    <= mvy_in;
      ridx_ff   <= ridx_in;
      rbody_ff  <= rbody_in;
      rlast_ff  <= rlast_in;
   end

   // Body memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[mem_raddr];
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_body_index  = ridx_ff;
   assign rsp_out_pos_x   = rbody_ff.pos_x;
   assign rsp_out_pos_y   = rbody_ff.pos_y;
   assign rsp_out_vel_x   = rbody_ff.vel_x;
   assign rsp_out_vel_y   = rbody_ff.vel_y;
   assign rsp_last_result = rlast_ff;

endmodule

### rtl/nbody_gravity_step_2d.sv
// Loading: one body per cycle; busy rises only when the two-entry queue is full.
// Run: per step each pair uses six divisions in the shared divider and two roots,
// plus fetch, arithmetic and write-back (a coincident pair skips all but the fetch
// and separation), N*(N-1)/2 pairs, then the position update of each body.
// Results: each strobed for one cycle, never back to back; the receiver cannot stall.
// Reset (synchronous): queue empty, load count zero, registers to defaults, memory kept.
module nbody_gravity_step_2d
   import nbgs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [31:0]           req_pos_x,
   input  logic [31:0]           req_pos_y,
   input  logic [31:0]           req_vel_x,
   input  logic [31:0]           req_vel_y,
   input  logic [25:0]           req_body_mass,
   input  logic                  req_last_body,
   output logic                  rsp_strobe,
   output logic [IDX_W-1:0]      rsp_body_index,
   output logic [31:0]           rsp_out_pos_x,
   output logic [31:0]           rsp_out_pos_y,
   output logic [31:0]           rsp_out_vel_x,
   output logic [31:0]           rsp_out_vel_y,
   output logic                  rsp_last_result,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_pop, q_full, q_empty;
   cmd_type push_cmd, pop_cmd;

   // Register writes; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BODY_COUNT: cfg_in.body_count    = csr_wdata[6:0];
            CSR_STEP_COUNT: cfg_in.step_count    = csr_wdata[15:0];
            CSR_GRAVITY:    cfg_in.gravity_const = csr_wdata[23:0];
            CSR_SOFTENING:  cfg_in.softening     = csr_wdata;
            CSR_TIME_STEP:  cfg_in.time_step     = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.body_count    <= RST_BODY_COUNT;
         cfg_ff.step_count    <= RST_STEP_COUNT;
         cfg_ff.gravity_const <= RST_GRAVITY;
         cfg_ff.softening     <= RST_SOFTENING;
         cfg_ff.time_step     <= RST_TIME_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nbgs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_body_mass (req_body_mass),
      .req_last_body (req_last_body),
      .body_count    (cfg_ff.body_count),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   nbgs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   nbgs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_cmd           (pop_cmd),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_body_index  (rsp_body_index),
      .rsp_out_pos_x   (rsp_out_pos_x),
      .rsp_out_pos_y   (rsp_out_pos_y),
      .rsp_out_vel_x   (rsp_out_vel_x),
      .rsp_out_vel_y   (rsp_out_vel_y),
      .rsp_last_result (rsp_last_result)
   );

endmodule

### rtl/nbgs_checker.sv
// Port-level checks for the gravity stepper, bound to the top level.
// Depends on nbgs_pkg and nbody_gravity_step_2d.
module nbgs_checker
   import nbgs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  busy,
   input logic                  rsp_strobe,
   input logic [IDX_W-1:0]      rsp_body_index,
   input logic                  rsp_last_result
);

   // Reset leaves the queue empty and no result pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("busy or strobe after reset");

   // Results are spaced by the memory read cycle
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // Within a run, indexes count up by one
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe, 2) && !$past(rsp_last_result, 2))
         |-> (rsp_body_index == IDX_W'($past(rsp_body_index, 2) + IDX_W'(1))))
      else $error("result index out of order");

   // The highest index can only be the end of a run
   a_top_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_result) |-> (rsp_body_index != IDX_W'(MAX_BODIES - 1)))
      else $error("highest index not marked last");

endmodule

bind nbody_gravity_step_2d nbgs_checker u_nbgs_checker (.*);

### test/tb_nbody_gravity_step_2d.sv
// Self-checking testbench for nbody_gravity_step_2d: loads bodies, runs the gravity
// steps in an internal fixed-point predictor and checks every reported body state.
// Depends on rtl/nbgs_pkg.sv and rtl/nbody_gravity_step_2d.sv.
`timescale 1ns / 1ps

module tb_nbody_gravity_step_2d;
   import nbgs_pkg::*;

   localparam int IDLE_LIMIT  = 400000;  // cycles with nothing moving before giving up
   localparam int DRAIN_WAIT  = 40;
   localparam int RAND_ITEMS  = 100;

   // Register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [31:0]      pos_x;
      logic [31:0]      pos_y;
      logic [31:0]      vel_x;
      logic [31:0]      vel_y;
      logic             last;
   } body_state_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [31:0] req_pos_x, req_pos_y, req_vel_x, req_vel_y;
   logic [25:0] req_body_mass;
   logic        req_last_body;
   logic        rsp_strobe;
   logic [IDX_W-1:0] rsp_body_index;
   logic [31:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_vel_x, rsp_out_vel_y;
   logic        rsp_last_result;
   logic        csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Predictor copy of the block's configuration and body memory
   logic [6:0]  cfg_bodies;
   logic [15:0] cfg_steps;
   logic [23:0] cfg_grav;
   logic [31:0] cfg_soft;
   logic [7:0]  cfg_dt;
   int          sim_px [MAX_BODIES];
   int          sim_py [MAX_BODIES];
   int          sim_vx [MAX_BODIES];
   int          sim_vy [MAX_BODIES];
   logic [25:0] sim_mass [MAX_BODIES];
   int          loaded;

   body_state_type final_states[$];
   int errors;
   int idle_cycles;
   int burst_left;

   nbody_gravity_step_2d dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y),
      .req_body_mass(req_body_mass), .req_last_body(req_last_body),
      .rsp_strobe(rsp_strobe), .rsp_body_index(rsp_body_index),
      .rsp_out_pos_x(rsp_out_pos_x), .rsp_out_pos_y(rsp_out_pos_y),
      .rsp_out_vel_x(rsp_out_vel_x), .rsp_out_vel_y(rsp_out_vel_y),
      .rsp_last_result(rsp_last_result),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------- predictor ----------------

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Acceleration magnitude, Q16.16, capped
   function automatic longint unsigned pull_of(logic [25:0] m, longint unsigned root,
                                               longint unsigned s);
      longint unsigned t;
      logic [81:0] q;
      t = ((64'(cfg_grav) * 64'(m)) << 14) / root;
      q = {t, 18'b0} / 82'(s);
      return (q > 82'(ACC_CAP)) ? 64'(ACC_CAP) : q[63:0];
   endfunction

   function automatic longint unsigned unit_of(longint unsigned a, longint unsigned half);
      longint unsigned u;
      u = (a << 29) / half;
      return (u > 64'(UNIT_ONE)) ? 64'(UNIT_ONE) : u;
   endfunction

   function automatic int kick(int v, bit toward_plus, longint unsigned f,
                               longint unsigned u);
      longint c;
      c = longint'((f * u) >> 30) * longint'(cfg_dt);
      return clamp32(longint'(v) + (toward_plus ? c : -c));
   endfunction

   task automatic interact(int i, int j);
      longint dx, dy;
      longint unsigned ax, ay, h2, s, root, half, ux, uy, fa, fb;
      logic [65:0] sq;
      dx = longint'(sim_px[j]) - longint'(sim_px[i]);
      dy = longint'(sim_py[j]) - longint'(sim_py[i]);
      if (dx == 0 && dy == 0) return;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
      h2 = 64'(sq >> 2);
      s = h2 + 64'(cfg_soft);
      if (s == 0) return;
      root = int_sqrt(s);
      half = int_sqrt(h2);
      if (half == 0) half = 1;
      ux = unit_of(ax, half);
      uy = unit_of(ay, half);
      fa = pull_of(sim_mass[j], root, s);
      fb = pull_of(sim_mass[i], root, s);
      sim_vx[i] = kick(sim_vx[i], dx >= 0, fa, ux);
      sim_vy[i] = kick(sim_vy[i], dy >= 0, fa, uy);
      sim_vx[j] = kick(sim_vx[j], dx < 0, fb, ux);
      sim_vy[j] = kick(sim_vy[j], dy < 0, fb, uy);
   endtask

   // Store one accepted request; on the last body, integrate and queue final states
   task automatic integrate_request(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                                    logic [31:0] vy, logic [25:0] m, logic last);
      int limit;
      body_state_type st;
      limit = (cfg_bodies < 2) ? 2 : ((cfg_bodies > MAX_BODIES) ? MAX_BODIES : cfg_bodies);
      if (loaded < limit) begin
         sim_px[loaded] = px;
         sim_py[loaded] = py;
         sim_vx[loaded] = vx;
         sim_vy[loaded] = vy;
         sim_mass[loaded] = m;
         loaded++;
      end
      if (!last) return;
      for (int t = 0; t < cfg_steps; t++) begin
         for (int i = 0; i < loaded; i++)
            for (int j = i + 1; j < loaded; j++)
               interact(i, j);
         for (int i = 0; i < loaded; i++) begin
            sim_px[i] = clamp32(longint'(sim_px[i]) + longint'(sim_vx[i]) * longint'(cfg_dt));
            sim_py[i] = clamp32(longint'(sim_py[i]) + longint'(sim_vy[i]) * longint'(cfg_dt));
         end
      end
      for (int i = 0; i < loaded; i++) begin
         st.index = IDX_W'(i);
         st.pos_x = sim_px[i];
         st.pos_y = sim_py[i];
         st.vel_x = sim_vx[i];
         st.vel_y = sim_vy[i];
         st.last  = (i + 1 == loaded);
         final_states.push_back(st);
      end
      loaded = 0;
   endtask

   // ---------------- checker and watchdog ----------------

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      body_state_type want;
      if (!reset && rsp_strobe) begin
         if (final_states.size() == 0) begin
            $display("%0t: unexpected body state, expected none, actual index %0d",
                     $time, rsp_body_index);
            errors++;
         end else begin
            want = final_states.pop_front();
            check_field("body_index", 32'(want.index), 32'(rsp_body_index));
            check_field("out_pos_x", want.pos_x, rsp_out_pos_x);
            check_field("out_pos_y", want.pos_y, rsp_out_pos_y);
            check_field("out_vel_x", want.vel_x, rsp_out_vel_x);
            check_field("out_vel_y", want.vel_y, rsp_out_vel_y);
            check_field("last_result", 32'(want.last), 32'(rsp_last_result));
         end
      end
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("nbody_gravity_step_2d test failed");
         $finish;
      end
   end

   // ---------------- drivers ----------------

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_BODY_COUNT: cfg_bodies = value[6:0];
         CSR_STEP_COUNT: cfg_steps = value[15:0];
         CSR_GRAVITY:    cfg_grav = value[23:0];
         CSR_SOFTENING:  cfg_soft = value;
         CSR_TIME_STEP:  cfg_dt = value[7:0];
         default: ;
      endcase
   endtask

   // Present one body request and hold it until the block takes it
   task automatic send_body(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                            logic [31:0] vy, logic [25:0] m, logic last);
      start <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_body_mass <= m;
      req_last_body <= last;
      do @(posedge clock); while (busy);
      integrate_request(px, py, vx, vy, m, last);
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Bursty sender: random burst lengths with random gaps (sometimes none)
   task automatic burst_gap();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 8);
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
   endtask

   // Hold off until every final state has come, then let the block settle
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (final_states.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
   endfunction

   function automatic logic [31:0] rand_speed();
      if ($urandom_range(0, 5) == 0) return $urandom;
      return 32'($urandom_range(0, 32'h0000_2000)) - 32'h0000_1000;
   endfunction

   function automatic logic [25:0] rand_mass();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 26'($urandom);
         default: return 26'($urandom_range(1, 32'h0004_0000));
      endcase
   endfunction

   // ---------------- tests ----------------

   // Saturating extremes, zero mass and a coincident pair at reset settings
   task automatic test_extremes();
      send_body(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 26'h3FF_FFFF, 0);
      send_body(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 26'h0, 0);
      send_body(32'h0, 32'h0, 32'h0, 32'h0, 26'h001_0000, 0);
      send_body(32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 26'h3FF_FFFF, 1);
      wait_idle();
   endtask

   // Load limit: extra bodies dropped, a dropped body still starts the run
   task automatic test_load_limit();
      write_reg(CSR_BODY_COUNT, 32'd0);
      send_body(32'h0001_0000, 32'h0, 32'h0, 32'h0, 26'h001_0000, 0);
      send_body(32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 26'h002_0000, 0);
      send_body(32'h1234_5678, 32'h0, 32'h0, 32'h0, 26'h3FF_FFFF, 1);
      wait_idle();
      write_reg(CSR_BODY_COUNT, 32'd1);
      send_body(32'h0, 32'h0002_0000, 32'h0, 32'h0, 26'h001_0000, 0);
      send_body(32'h0, 32'hFFFE_0000, 32'h0, 32'h0, 26'h001_0000, 0);
      send_body(32'h0, 32'h0, 32'h0, 32'h0, 26'h001_0000, 1);
      wait_idle();
      write_reg(CSR_BODY_COUNT, 32'd127);
      // single loaded body: motion only
      send_body(32'h0003_0000, 32'h0, 32'h0000_8000, 32'hFFFF_8000, 26'h001_0000, 1);
      wait_idle();
   endtask

   // No steps, then steps with a zero time step
   task automatic test_zero_steps();
      write_reg(CSR_STEP_COUNT, 32'd0);
      send_body(32'h0001_0000, 32'h0001_0000, 32'h0000_0100, 32'h0, 26'h001_0000, 0);
      send_body(32'hFFFF_0000, 32'h0002_0000, 32'h0, 32'h0000_0100, 26'h001_0000, 1);
      wait_idle();
      write_reg(CSR_STEP_COUNT, 32'd2);
      write_reg(CSR_TIME_STEP, 32'd0);
      send_body(32'h0001_0000, 32'h0, 32'h0, 32'h0, 26'h001_0000, 0);
      send_body(32'h0, 32'h0001_0000, 32'h0, 32'h0, 26'h002_0000, 0);
      send_body(32'hFFFF_0000, 32'hFFFF_0000, 32'h0, 32'h0, 26'h003_0000, 1);
      wait_idle();
   endtask

   // Register extremes and writes to unused indexes
   task automatic test_register_extremes();
      write_reg(CSR_STEP_COUNT, 32'd1);
      write_reg(CSR_GRAVITY, 32'h00FF_FFFF);
      write_reg(CSR_SOFTENING, 32'hFFFF_FFFF);
      write_reg(CSR_TIME_STEP, 32'd255);
      send_body(32'h0000_4000, 32'h0, 32'h0, 32'h0, 26'h3FF_FFFF, 0);
      send_body(32'h0, 32'h0000_4000, 32'h0, 32'h0, 26'h3FF_FFFF, 0);
      send_body(32'h0, 32'h0, 32'h0, 32'h0, 26'h000_0001, 1);
      wait_idle();
      write_reg(CSR_GRAVITY, 32'd1);
      write_reg(CSR_SOFTENING, 32'd0);
      write_reg(CSR_TIME_STEP, 32'd1);
      write_reg(CSR_SPARE_LO, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_HI, 32'hFFFF_FFFF);
      send_body(32'h0000_0001, 32'h0, 32'h0, 32'h0, 26'h3FF_FFFF, 0);
      send_body(32'h0, 32'h0, 32'h0, 32'h0, 26'h3FF_FFFF, 1);
      wait_idle();
   endtask

   // Random settings and body sets, bursty sender
   task automatic test_random_runs();
      int sent;
      int group;
      sent = 0;
      while (sent < RAND_ITEMS) begin
         case ($urandom_range(0, 5))
            0: write_reg(CSR_BODY_COUNT, 32'd64);
            1: write_reg(CSR_BODY_COUNT, 32'($urandom_range(0, 127)));
            default: write_reg(CSR_BODY_COUNT, 32'($urandom_range(2, 6)));
         endcase
         write_reg(CSR_STEP_COUNT, 32'($urandom_range(1, 2)));
         write_reg(CSR_GRAVITY, ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 24'hFF_FFFF))
                                                             : 32'($urandom_range(1, 24'h04_0000)));
         write_reg(CSR_SOFTENING, ($urandom_range(0, 2) == 0) ? $urandom
                                                               : 32'($urandom_range(0, 1000000)));
         write_reg(CSR_TIME_STEP, ($urandom_range(0, 4) == 0) ? 32'($urandom_range(1, 255))
                                                              : 32'($urandom_range(1, 4)));
         group = $urandom_range(1, 6);
         for (int k = 0; k < group; k++) begin
            send_body(rand_coord(), rand_coord(), rand_speed(), rand_speed(), rand_mass(),
                      k == group - 1);
            burst_gap();
            sent++;
         end
         wait_idle();
      end
   endtask

   initial begin
      errors = 0;
      burst_left = 0;
      idle_cycles = 0;
      loaded = 0;
      cfg_bodies = RST_BODY_COUNT;
      cfg_steps = RST_STEP_COUNT;
      cfg_grav = RST_GRAVITY;
      cfg_soft = RST_SOFTENING;
      cfg_dt = RST_TIME_STEP;
      reset = 1'b1;
      start = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_body_mass = '0;
      req_last_body = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_load_limit();
      test_zero_steps();
      test_register_extremes();
      test_random_runs();

      wait_idle();
      if (errors == 0 && final_states.size() == 0) begin
         $display("nbody_gravity_step_2d test passed");
      end else begin
         $display("nbody_gravity_step_2d test failed");
      end
      $finish;
   end

endmodule
